[rtl/fscs_pkg.sv]
// Shared types and constants for the serial configuration supervisor.
`default_nettype none

package fscs_pkg;

    localparam int TIMER_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_TIMER_W = 16;
    localparam int OUT_COUNT_W = 24;
    localparam int BEAT_W      = 3;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam logic [CFG_TIMER_W-1:0] CHECK_INTERVAL_RST = 16'd10;
    localparam logic [CFG_TIMER_W-1:0] SETTLE_TIME_RST    = 16'd1;
    localparam logic [CFG_TIMER_W-1:0] RETRY_WAIT_RST     = 16'd300;

    typedef enum logic [1:0] {
        PH_WATCH  = 2'd0,
        PH_SEND   = 2'd1,
        PH_SETTLE = 2'd2,
        PH_RETRY  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_START      = 3'd1,
        EV_SUCCESS    = 3'd2,
        EV_FAILED     = 3'd3,
        EV_IGNORED    = 3'd4,
        EV_CONFIGURED = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        CK_SINGLE = 2'd0,
        CK_START  = 2'd1,
        CK_BYTE   = 2'd2
    } t_cmd_kind;

    typedef enum logic [2:0] {
        REG_FORCE_A        = 3'd0,
        REG_FORCE_X        = 3'd1,
        REG_CHECK_INTERVAL = 3'd2,
        REG_SETTLE_TIME    = 3'd3,
        REG_RETRY_WAIT     = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                   force_first_a;
        logic                   force_first_x;
        logic [CFG_TIMER_W-1:0] check_interval;
        logic [CFG_TIMER_W-1:0] settle_time;
        logic [CFG_TIMER_W-1:0] retry_wait;
    } t_cfg;

    typedef struct packed {
        t_cmd_kind              kind;
        t_event                 event_res;
        logic                   target;
        t_phase                 phase;
        logic [OUT_COUNT_W-1:0] bytes_sent;
        logic [7:0]             image_byte;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/fscs_queue.sv]
// Short command queue between the front and back parts.
`default_nettype none

module fscs_queue
    import fscs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  wire  i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/fscs_front.sv]
// Front part: supervisor state machine that classifies each item into a command.
`default_nettype none

module fscs_front
    import fscs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_fire,
    input  wire        i_kind,
    input  wire        i_done_a,
    input  wire        i_done_x,
    input  wire  [7:0] i_image_byte,
    input  wire        i_image_last,
    input  t_cfg       i_cfg,
    output t_cmd       o_cmd
);

    localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CFG_TIMER_W-1:0] v);
        logic [32:0] wide;
        wide = 33'(v);
        if (v == '0) begin
            timer_load = TIMER_BITS'(1);
        end else if (wide > TMAX) begin
            timer_load = TMAX[TIMER_BITS-1:0];
        end else begin
            timer_load = TIMER_BITS'(v);
        end
    endfunction

    t_phase                r_phase, n_phase;
    logic                  r_target, n_target;
    logic                  r_first, n_first;
    logic [TIMER_BITS-1:0] r_tick, n_tick;
    logic [COUNT_BITS-1:0] r_bcnt, n_bcnt;

    logic [TIMER_BITS-1:0] tick_dec;
    logic                  tick_zero;
    logic                  check;
    logic                  force_a, force_x;
    logic                  quiet;
    logic                  start_tgt;
    logic                  done_ok;

    assign tick_dec  = (r_tick != '0) ? r_tick - 1'b1 : '0;
    assign tick_zero = (tick_dec == '0);
    assign check     = r_first || tick_zero;
    assign force_a   = r_first && i_cfg.force_first_a;
    assign force_x   = r_first && i_cfg.force_first_x;
    assign quiet     = !force_a && !force_x && i_done_a && i_done_x;
    assign start_tgt = force_a ? 1'b0 : (force_x || !i_done_x);
    assign done_ok   = r_target ? i_done_x : i_done_a;

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_target = r_target;
        n_first  = r_first;
        n_tick   = r_tick;
        n_bcnt   = r_bcnt;
        if (i_fire) begin
            if (i_kind) begin
                if (r_phase == PH_SEND) begin
                    if (r_bcnt != CNT_MAX) begin
                        n_bcnt = r_bcnt + 1'b1;
                    end
                    if (i_image_last) begin
                        n_phase = PH_SETTLE;
                        n_tick  = timer_load(i_cfg.settle_time);
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_WATCH: begin
                        if (check) begin
                            n_first = 1'b0;
                            if (quiet) begin
                                n_tick = timer_load(i_cfg.check_interval);
                            end else begin
                                n_target = start_tgt;
                                n_phase  = PH_SEND;
                                n_bcnt   = '0;
                                n_tick   = '0;
                            end
                        end else begin
                            n_tick = tick_dec;
                        end
                    end
                    PH_SETTLE: begin
                        if (tick_zero) begin
                            if (done_ok) begin
                                n_phase = PH_WATCH;
                                n_tick  = timer_load(i_cfg.check_interval);
                            end else begin
                                n_phase = PH_RETRY;
                                n_tick  = timer_load(i_cfg.retry_wait);
                            end
                        end else begin
                            n_tick = tick_dec;
                        end
                    end
                    PH_RETRY: begin
                        if (tick_zero) begin
                            n_phase = PH_WATCH;
                            n_tick  = timer_load(i_cfg.check_interval);
                        end else begin
                            n_tick = tick_dec;
                        end
                    end
                    PH_SEND: begin
                    end
                endcase
            end
        end
    end

    // command for the back part; it carries the state after this item
    always_comb begin
        o_cmd.kind       = CK_SINGLE;
        o_cmd.event_res  = EV_NONE;
        o_cmd.target     = n_target;
        o_cmd.phase      = n_phase;
        o_cmd.bytes_sent = OUT_COUNT_W'(n_bcnt);
        o_cmd.image_byte = i_image_byte;
        if (i_kind) begin
            if (r_phase == PH_SEND) begin
                o_cmd.kind = CK_BYTE;
            end else begin
                o_cmd.event_res = EV_IGNORED;
            end
        end else begin
            unique case (r_phase)
                PH_WATCH: begin
                    if (check) begin
                        if (quiet) begin
                            o_cmd.event_res = r_first ? EV_CONFIGURED : EV_NONE;
                        end else begin
                            o_cmd.kind = CK_START;
                        end
                    end
                end
                PH_SETTLE: begin
                    if (tick_zero) begin
                        o_cmd.event_res = done_ok ? EV_SUCCESS : EV_FAILED;
                    end
                end
                PH_RETRY, PH_SEND: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WATCH;
            r_target <= 1'b0;
            r_first  <= 1'b1;
            r_tick   <= '0;
            r_bcnt   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_target <= n_target;
            r_first  <= n_first;
            r_tick   <= n_tick;
            r_bcnt   <= n_bcnt;
        end
    end

endmodule

`default_nettype wire

[rtl/fscs_back.sv]
// Back part: expands queued commands into result beats, one bit per beat for bytes.
`default_nettype none

module fscs_back
    import fscs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_q_empty,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    input  wire         i_pop,
    output logic        o_empty,
    output logic        o_data_pin,
    output logic        o_clock_strobe,
    output logic        o_prog_n_a,
    output logic        o_prog_n_x,
    output logic        o_target,
    output logic [1:0]  o_phase,
    output logic [2:0]  o_event_res,
    output logic [23:0] o_bytes_sent,
    output logic        o_last_of_run
);

    t_cmd              r_cmd;
    logic              r_valid;
    logic [BEAT_W-1:0] r_beat;
    logic              cmd_done;
    logic              load;
    logic              start_beat;

    always_comb begin
        unique case (r_cmd.kind)
            CK_BYTE:  cmd_done = (r_beat == BEAT_W'(7));
            CK_START: cmd_done = r_beat[0];
            default:  cmd_done = 1'b1;
        endcase
    end

    assign load       = !r_valid || (i_pop && cmd_done);
    assign o_q_pop    = load && !i_q_empty;
    assign start_beat = (r_cmd.kind == CK_START) && !r_beat[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else if (load) begin
            r_valid <= !i_q_empty;
            r_beat  <= '0;
        end else if (i_pop) begin
            r_beat <= r_beat + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    assign o_empty        = !r_valid;
    assign o_clock_strobe = (r_cmd.kind == CK_BYTE);
    // X takes MSB first, A takes LSB first
    assign o_data_pin     = o_clock_strobe &&
                            (r_cmd.target ? r_cmd.image_byte[BEAT_W'(7) - r_beat]
                                          : r_cmd.image_byte[r_beat]);
    assign o_prog_n_a     = !(start_beat && !r_cmd.target);
    assign o_prog_n_x     = !(start_beat && r_cmd.target);
    assign o_target       = r_cmd.target;
    assign o_phase        = r_cmd.phase;
    assign o_event_res    = start_beat ? EV_START
                          : (r_cmd.kind == CK_START) ? EV_NONE : r_cmd.event_res;
    assign o_bytes_sent   = r_cmd.bytes_sent;
    assign o_last_of_run  = cmd_done;

endmodule

`default_nettype wire

[rtl/fpga_serial_config_supervisor.sv]
// A result reaches the ports once its command has passed the queue and been loaded
// into the back part's command register. Throughput: one item per cycle into a
// command queue while it is not full; results leave at one beat per cycle while
// pop is held; an image byte gives 8 beats, a programming start 2, any other item 1.
// The queue depth sets how far the front runs ahead. Synchronous active-low reset
// returns the registers to their defaults, empties the queue and restarts watching.
`default_nettype none

module fpga_serial_config_supervisor
    import fscs_pkg::*;
#(
    parameter int TIMER_BITS  = TIMER_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_ADDR_W-1:0] paddr,
    input  wire  [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  wire                   push,
    output logic                  full,
    input  wire                   i_kind,
    input  wire                   i_done_a,
    input  wire                   i_done_x,
    input  wire  [7:0]            i_image_byte,
    input  wire                   i_image_last,
    output logic                  empty,
    input  wire                   pop,
    output logic                  o_data_pin,
    output logic                  o_clock_strobe,
    output logic                  o_prog_n_a,
    output logic                  o_prog_n_x,
    output logic                  o_target,
    output logic [1:0]            o_phase,
    output logic [2:0]            o_event_res,
    output logic [23:0]           o_bytes_sent,
    output logic                  o_last_of_run
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     fire;
    t_cmd     front_cmd;
    t_cmd     q_cmd;
    logic     q_empty;
    logic     q_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.force_first_a  <= 1'b0;
            r_cfg.force_first_x  <= 1'b0;
            r_cfg.check_interval <= CHECK_INTERVAL_RST;
            r_cfg.settle_time    <= SETTLE_TIME_RST;
            r_cfg.retry_wait     <= RETRY_WAIT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FORCE_A:        r_cfg.force_first_a  <= pwdata[0];
                REG_FORCE_X:        r_cfg.force_first_x  <= pwdata[0];
                REG_CHECK_INTERVAL: r_cfg.check_interval <= pwdata[CFG_TIMER_W-1:0];
                REG_SETTLE_TIME:    r_cfg.settle_time    <= pwdata[CFG_TIMER_W-1:0];
                REG_RETRY_WAIT:     r_cfg.retry_wait     <= pwdata[CFG_TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FORCE_A:        prdata = APB_DATA_W'(r_cfg.force_first_a);
            REG_FORCE_X:        prdata = APB_DATA_W'(r_cfg.force_first_x);
            REG_CHECK_INTERVAL: prdata = APB_DATA_W'(r_cfg.check_interval);
            REG_SETTLE_TIME:    prdata = APB_DATA_W'(r_cfg.settle_time);
            REG_RETRY_WAIT:     prdata = APB_DATA_W'(r_cfg.retry_wait);
            default:            prdata = '0;
        endcase
    end

    assign fire = push && !full;

    fscs_front #(
        .TIMER_BITS (TIMER_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_kind       (i_kind),
        .i_done_a     (i_done_a),
        .i_done_x     (i_done_x),
        .i_image_byte (i_image_byte),
        .i_image_last (i_image_last),
        .i_cfg        (r_cfg),
        .o_cmd        (front_cmd)
    );

    fscs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    fscs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_cmd        (q_cmd),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_data_pin     (o_data_pin),
        .o_clock_strobe (o_clock_strobe),
        .o_prog_n_a     (o_prog_n_a),
        .o_prog_n_x     (o_prog_n_x),
        .o_target       (o_target),
        .o_phase        (o_phase),
        .o_event_res    (o_event_res),
        .o_bytes_sent   (o_bytes_sent),
        .o_last_of_run  (o_last_of_run)
    );

    // never pulse both nConfig lines at once
    a_one_nconfig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_prog_n_a || o_prog_n_x))
        else $error("both nConfig lines asserted");

    a_strobe_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_clock_strobe) |-> (o_event_res == EV_NONE))
        else $error("event reported on a strobed bit beat");

    // bit beats of one byte follow each other without a gap
    a_byte_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_clock_strobe && !o_last_of_run) |=>
            (!empty && o_clock_strobe))
        else $error("byte expansion broke off early");

    // the start beat is followed by the release beat
    a_start_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && (o_event_res == EV_START)) |=>
            (!empty && o_prog_n_a && o_prog_n_x && o_last_of_run &&
             (o_event_res == EV_NONE)))
        else $error("start beat not followed by release beat");

endmodule

`default_nettype wire

[bench/fpga_serial_config_supervisor_tb.sv]
// Self-checking testbench for the serial configuration supervisor.
module fpga_serial_config_supervisor_tb
    import fscs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                   data_pin;
        logic                   clock_strobe;
        logic                   prog_n_a;
        logic                   prog_n_x;
        logic                   target;
        t_phase                 phase;
        t_event                 event_res;
        logic [OUT_COUNT_W-1:0] bytes_sent;
        logic                   last_of_run;
    } t_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push = 1'b0;
    logic                  full;
    logic                  i_kind = 1'b0;
    logic                  i_done_a = 1'b0;
    logic                  i_done_x = 1'b0;
    logic [7:0]            i_image_byte = '0;
    logic                  i_image_last = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  o_data_pin;
    logic                  o_clock_strobe;
    logic                  o_prog_n_a;
    logic                  o_prog_n_x;
    logic                  o_target;
    logic [1:0]            o_phase;
    logic [2:0]            o_event_res;
    logic [23:0]           o_bytes_sent;
    logic                  o_last_of_run;

    // Predicted supervisor state and register copy
    t_cfg                   cfg;
    t_phase                 sup_phase;
    logic                   sup_target;
    logic                   sup_first;
    logic [CFG_TIMER_W-1:0] sup_ticks;
    logic [OUT_COUNT_W-1:0] sup_bytes;

    t_beat expected_beats[$];

    int mismatches = 0;
    int items_sent = 0;
    int beats_checked = 0;
    int starts = 0;
    int successes = 0;
    int failures = 0;
    int pop_hold = 0;
    bit no_idle = 1'b0;

    fpga_serial_config_supervisor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_done_a       (i_done_a),
        .i_done_x       (i_done_x),
        .i_image_byte   (i_image_byte),
        .i_image_last   (i_image_last),
        .empty          (empty),
        .pop            (pop),
        .o_data_pin     (o_data_pin),
        .o_clock_strobe (o_clock_strobe),
        .o_prog_n_a     (o_prog_n_a),
        .o_prog_n_x     (o_prog_n_x),
        .o_target       (o_target),
        .o_phase        (o_phase),
        .o_event_res    (o_event_res),
        .o_bytes_sent   (o_bytes_sent),
        .o_last_of_run  (o_last_of_run)
    );

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_TIMER_W-1:0] load_timer(input logic [CFG_TIMER_W-1:0] v);
        return (v == '0) ? CFG_TIMER_W'(1) : v;
    endfunction

    function automatic t_beat mk_beat(input logic data, strobe, nca, ncx, input t_event ev);
        t_beat b;
        b.data_pin     = data;
        b.clock_strobe = strobe;
        b.prog_n_a     = nca;
        b.prog_n_x     = ncx;
        b.target       = sup_target;
        b.phase        = sup_phase;
        b.event_res    = ev;
        b.bytes_sent   = sup_bytes;
        b.last_of_run  = 1'b0;
        return b;
    endfunction

    function automatic string fmt_beat(input t_beat b);
        return $sformatf({"data=%0b strobe=%0b nca=%0b ncx=%0b tgt=%0b ph=%0d ev=%0d",
                          " bytes=%0d last=%0b"},
                         b.data_pin, b.clock_strobe, b.prog_n_a, b.prog_n_x, b.target,
                         b.phase, b.event_res, b.bytes_sent, b.last_of_run);
    endfunction

    function automatic void reset_supervisor_model();
        cfg.force_first_a  = 1'b0;
        cfg.force_first_x  = 1'b0;
        cfg.check_interval = CHECK_INTERVAL_RST;
        cfg.settle_time    = SETTLE_TIME_RST;
        cfg.retry_wait     = RETRY_WAIT_RST;
        sup_phase  = PH_WATCH;
        sup_target = 1'b0;
        sup_first  = 1'b1;
        sup_ticks  = '0;
        sup_bytes  = '0;
    endfunction

    function automatic void apply_reg(input t_reg_idx idx, input logic [31:0] value);
        case (idx)
            REG_FORCE_A:        cfg.force_first_a  = value[0];
            REG_FORCE_X:        cfg.force_first_x  = value[0];
            REG_CHECK_INTERVAL: cfg.check_interval = value[CFG_TIMER_W-1:0];
            REG_SETTLE_TIME:    cfg.settle_time    = value[CFG_TIMER_W-1:0];
            REG_RETRY_WAIT:     cfg.retry_wait     = value[CFG_TIMER_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the predicted state by one item and queue the beats it produces.
    function automatic void predict_supervisor(input logic kind, da, dx,
                                               input logic [7:0] b, input logic last);
        t_beat run [8];
        int    n;
        int    i;
        logic  first;
        logic  fa;
        logic  fx;
        logic  ok;
        n = 0;
        if (kind) begin
            if (sup_phase != PH_SEND) begin
                run[0] = mk_beat(1'b0, 1'b0, 1'b1, 1'b1, EV_IGNORED);
                n = 1;
            end else begin
                if (sup_bytes != '1) sup_bytes++;
                if (last) begin
                    sup_phase = PH_SETTLE;
                    sup_ticks = load_timer(cfg.settle_time);
                end
                // A takes the byte LSB first, X MSB first
                for (i = 0; i < 8; i++)
                    run[i] = mk_beat(sup_target ? b[7-i] : b[i],
                                     1'b1, 1'b1, 1'b1, EV_NONE);
                n = 8;
            end
        end else if (sup_phase == PH_WATCH) begin
            if (sup_ticks != '0) sup_ticks--;
            if (!sup_first && sup_ticks != '0) begin
                run[0] = mk_beat(1'b0, 1'b0, 1'b1, 1'b1, EV_NONE);
                n = 1;
            end else begin
                first = sup_first;
                fa = first & cfg.force_first_a;
                fx = first & cfg.force_first_x;
                sup_first = 1'b0;
                if (!fa && !fx && da && dx) begin
                    sup_ticks = load_timer(cfg.check_interval);
                    run[0] = mk_beat(1'b0, 1'b0, 1'b1, 1'b1, first ? EV_CONFIGURED : EV_NONE);
                    n = 1;
                end else begin
                    sup_target = fa ? 1'b0 : (fx || !dx);
                    sup_phase  = PH_SEND;
                    sup_bytes  = '0;
                    sup_ticks  = '0;
                    run[0] = mk_beat(1'b0, 1'b0, sup_target, !sup_target, EV_START);
                    run[1] = mk_beat(1'b0, 1'b0, 1'b1, 1'b1, EV_NONE);
                    n = 2;
                    starts++;
                end
            end
        end else if (sup_phase == PH_SETTLE) begin
            if (sup_ticks != '0) sup_ticks--;
            if (sup_ticks == '0) begin
                ok = sup_target ? dx : da;
                if (ok) begin
                    sup_phase = PH_WATCH;
                    sup_ticks = load_timer(cfg.check_interval);
                    run[0] = mk_beat(1'b0, 1'b0, 1'b1, 1'b1, EV_SUCCESS);
                    successes++;
                end else begin
                    sup_phase = PH_RETRY;
                    sup_ticks = load_timer(cfg.retry_wait);
                    run[0] = mk_beat(1'b0, 1'b0, 1'b1, 1'b1, EV_FAILED);
                    failures++;
                end
            end else begin
                run[0] = mk_beat(1'b0, 1'b0, 1'b1, 1'b1, EV_NONE);
            end
            n = 1;
        end else if (sup_phase == PH_RETRY) begin
            if (sup_ticks != '0) sup_ticks--;
            if (sup_ticks == '0) begin
                sup_phase = PH_WATCH;
                sup_ticks = load_timer(cfg.check_interval);
            end
            run[0] = mk_beat(1'b0, 1'b0, 1'b1, 1'b1, EV_NONE);
            n = 1;
        end else begin
            // tick while sending: no change
            run[0] = mk_beat(1'b0, 1'b0, 1'b1, 1'b1, EV_NONE);
            n = 1;
        end
        run[n-1].last_of_run = 1'b1;
        for (i = 0; i < n; i++) expected_beats.push_back(run[i]);
    endfunction

    task automatic send_item(input logic kind, da, dx, input logic [7:0] b, input logic last);
        int gap;
        push         <= 1'b1;
        i_kind       <= kind;
        i_done_a     <= da;
        i_done_x     <= dx;
        i_image_byte <= b;
        i_image_last <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_supervisor(kind, da, dx, b, last);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic tick(input logic da, dx);
        send_item(1'b0, da, dx, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic image(input logic [7:0] b, input logic last);
        send_item(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), b, last);
    endtask

    task automatic start_program(input logic da, dx);
        while (sup_phase != PH_SEND) tick(da, dx);
    endtask

    // Hold the sender until every expected beat is in, then let the pipe settle.
    task automatic wait_drain();
        push <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        apply_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_timers(input int ci, st, rw);
        write_reg(REG_CHECK_INTERVAL, ci);
        write_reg(REG_SETTLE_TIME, st);
        write_reg(REG_RETRY_WAIT, rw);
    endtask

    task automatic set_forces(input logic fa, fx);
        write_reg(REG_FORCE_A, {31'd0, fa});
        write_reg(REG_FORCE_X, {31'd0, fx});
    endtask

    // First check with random force flags, every event kind (configured only if no flag is set), both bit orders.
    task automatic test_directed();
        set_forces(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        set_timers(2, 1, 2);
        image(8'h3C, 1'b1);
        tick(1'b1, 1'b1);
        if (sup_phase == PH_SEND) begin
            image(8'h00, 1'b0);
            image(8'hFF, 1'b0);
            image(8'h80, 1'b0);
            image(8'h01, 1'b1);
            tick(1'b1, 1'b1);
        end
        start_program(1'b1, 1'b0);
        image(8'hA5, 1'b0);
        tick(1'b0, 1'b0);
        image(8'h5A, 1'b1);
        tick(1'b0, 1'b0);
        while (sup_phase == PH_RETRY) tick(1'b1, 1'b1);
        start_program(1'b0, 1'b1);
        image(8'hC3, 1'b1);
        tick(1'b1, 1'b1);
        wait_drain();
    endtask

    // Stall the receiver long enough for the block to fill and push back.
    task automatic test_fill_stall();
        int k;
        no_idle = 1'b1;
        start_program(1'b0, 1'b0);
        pop_hold = 300;
        for (k = 0; k < 12; k++) image(8'($urandom_range(0, 255)), k == 11);
        tick(1'b1, 1'b1);
        no_idle = 1'b0;
        wait_drain();
    endtask

    // Zero timer values and longer waits in every timed phase; no idling here.
    task automatic test_timer_extremes();
        no_idle = 1'b1;
        start_program(1'b0, 1'b0);
        wait_drain();
        set_timers(0, 9, 7);
        image(8'h96, 1'b1);
        while (sup_phase == PH_SETTLE) tick(1'b0, 1'b0);
        while (sup_phase == PH_RETRY) tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        wait_drain();
        write_reg(REG_CHECK_INTERVAL, 8);
        tick(1'b1, 1'b1);
        while (sup_phase == PH_WATCH) tick(1'b1, 1'b0);
        wait_drain();
        set_timers(3, 0, 0);
        image(8'h81, 1'b1);
        tick(1'b0, 1'b1);
        no_idle = 1'b0;
        wait_drain();
    endtask

    // Mostly well-formed programming runs with random content, plus noise.
    task automatic test_random_traffic();
        int counted;
        int next_cfg;
        counted  = 0;
        next_cfg = 0;
        while (counted < 90) begin
            if (counted >= next_cfg) begin
                wait_drain();
                no_idle = ($urandom_range(0, 3) == 0);
                set_forces(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                set_timers($urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 6));
                next_cfg += 30;
            end
            if (sup_phase == PH_SEND) begin
                if ($urandom_range(0, 9) < 8)
                    image(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
                else
                    tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                counted++;
            end else if ($urandom_range(0, 9) == 0) begin
                image(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                if ($urandom_range(0, 1)) tick(1'b1, 1'b1);
                else tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                counted++;
            end
        end
        no_idle = 1'b0;
        wait_drain();
    endtask

    // Receiver: random gaps, plus a long hold-off when a test asks for one.
    initial begin
        int gap;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (pop_hold > 0) begin
                pop <= 1'b0;
                pop_hold--;
            end else if (gap > 0) begin
                pop <= 1'b0;
                gap--;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0) gap = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (i_rst_n && pop && !empty) begin
            got.data_pin     = o_data_pin;
            got.clock_strobe = o_clock_strobe;
            got.prog_n_a     = o_prog_n_a;
            got.prog_n_x     = o_prog_n_x;
            got.target       = o_target;
            got.phase        = t_phase'(o_phase);
            got.event_res    = t_event'(o_event_res);
            got.bytes_sent   = o_bytes_sent;
            got.last_of_run  = o_last_of_run;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat %0d: got %s", beats_checked, fmt_beat(got));
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected %s, got %s",
                                 beats_checked, fmt_beat(want), fmt_beat(got));
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        reset_supervisor_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_stall();
        test_timer_extremes();
        test_random_traffic();
        wait_drain();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d items and %0d result beats: directed events, back-pressure,",
                 items_sent, beats_checked);
        $display("zero and longer timers, random runs; %0d starts, %0d successes, %0d failures.",
                 starts, successes, failures);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/fscs_pkg.sv
rtl/fscs_queue.sv
rtl/fscs_front.sv
rtl/fscs_back.sv
rtl/fpga_serial_config_supervisor.sv
bench/fpga_serial_config_supervisor_tb.sv
